// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL; bodies vanish under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every edge outside reset.
`define GTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("gts assertion failed");
// Property must never hold outside reset.
`define GTS_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(prop)) \
    else $error("gts forbidden condition seen");
`else
`define GTS_ASSERT(lbl, clk, rstn, prop)
`define GTS_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

// File: rtl/gts_pkg.sv
package gts_pkg;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned CountW  = 4;
  localparam int unsigned StepSqW = 2 * CoordW + 1;
  localparam int unsigned PointsW = 10;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [CountW-1:0]  CountMax  = '1;
  localparam logic [PointsW-1:0] PointsMax = '1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ARM     = 2'd1,
    PH_COLLECT = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    REG_ARM_FRAMES     = 3'd0,
    REG_RELEASE_FRAMES = 3'd1,
    REG_MIN_STEP_SQ    = 3'd2,
    REG_MAX_STEP_SQ    = 3'd3,
    REG_MIN_POINTS     = 3'd4,
    REG_TAIL_TRIM      = 3'd5
  } reg_idx_e;

  localparam logic [CountW-1:0]  RstArmFrames     = 4'd3;
  localparam logic [CountW-1:0]  RstReleaseFrames = 4'd3;
  localparam logic [StepSqW-1:0] RstMinStepSq     = 25'd16;
  localparam logic [StepSqW-1:0] RstMaxStepSq     = 25'd10000;
  localparam logic [PointsW-1:0] RstMinPoints     = 10'd10;
  localparam logic [CountW-1:0]  RstTailTrim      = 4'd5;

  typedef struct packed {
    logic [CountW-1:0]  arm_frames;
    logic [CountW-1:0]  release_frames;
    logic [StepSqW-1:0] min_step_sq;
    logic [StepSqW-1:0] max_step_sq;
    logic [PointsW-1:0] min_points;
    logic [CountW-1:0]  tail_trim;
  } cfg_t;

  typedef struct packed {
    logic              hand_closed;
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
  } item_t;

  typedef struct packed {
    logic              append_point;
    logic [CoordW-1:0] kept_x;
    logic [CoordW-1:0] kept_y;
    logic              clear_sequence;
    logic              gesture_ready;
    logic [CountW-1:0] trim_count;
    logic [1:0]        phase;
  } res_t;

endpackage

// File: rtl/gts_cfg_regs.sv
module gts_cfg_regs import gts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);

  // Decode the write beat into the addressed register.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ARM_FRAMES:     cfg_d.arm_frames     = pwdata[CountW-1:0];
        REG_RELEASE_FRAMES: cfg_d.release_frames = pwdata[CountW-1:0];
        REG_MIN_STEP_SQ:    cfg_d.min_step_sq    = pwdata[StepSqW-1:0];
        REG_MAX_STEP_SQ:    cfg_d.max_step_sq    = pwdata[StepSqW-1:0];
        REG_MIN_POINTS:     cfg_d.min_points     = pwdata[PointsW-1:0];
        REG_TAIL_TRIM:      cfg_d.tail_trim      = pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero outside the map.
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ARM_FRAMES:     prdata[CountW-1:0]  = cfg_q.arm_frames;
      REG_RELEASE_FRAMES: prdata[CountW-1:0]  = cfg_q.release_frames;
      REG_MIN_STEP_SQ:    prdata[StepSqW-1:0] = cfg_q.min_step_sq;
      REG_MAX_STEP_SQ:    prdata[StepSqW-1:0] = cfg_q.max_step_sq;
      REG_MIN_POINTS:     prdata[PointsW-1:0] = cfg_q.min_points;
      REG_TAIL_TRIM:      prdata[CountW-1:0]  = cfg_q.tail_trim;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arm_frames     <= RstArmFrames;
      cfg_q.release_frames <= RstReleaseFrames;
      cfg_q.min_step_sq    <= RstMinStepSq;
      cfg_q.max_step_sq    <= RstMaxStepSq;
      cfg_q.min_points     <= RstMinPoints;
      cfg_q.tail_trim      <= RstTailTrim;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/gts_core.sv
`include "assert_macros.svh"

module gts_core import gts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   arm_cnt_q, arm_cnt_d;
  logic [CountW-1:0]   open_cnt_q, open_cnt_d;
  logic [PointsW-1:0]  kept_q, kept_d;
  logic [CoordW-1:0]   last_x_q, last_x_d;
  logic [CoordW-1:0]   last_y_q, last_y_d;

  logic [CoordW-1:0]   dx, dy;
  logic [2*CoordW-1:0] dx_sq, dy_sq;
  logic [StepSqW-1:0]  dist_sq;
  logic                in_bounds;
  logic [CountW-1:0]   arm_inc, open_inc;

  // Squared step from the last kept point; widths hold the worst case exactly.
  assign dx = (item_i.point_x >= last_x_q) ? item_i.point_x - last_x_q
                                            : last_x_q - item_i.point_x;
  assign dy = (item_i.point_y >= last_y_q) ? item_i.point_y - last_y_q
                                            : last_y_q - item_i.point_y;
  assign dx_sq   = {{CoordW{1'b0}}, dx} * {{CoordW{1'b0}}, dx};
  assign dy_sq   = {{CoordW{1'b0}}, dy} * {{CoordW{1'b0}}, dy};
  assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign in_bounds = (dist_sq >= cfg_i.min_step_sq) && (dist_sq <= cfg_i.max_step_sq);

  // Saturating counter increments.
  assign arm_inc  = (arm_cnt_q  == CountMax) ? CountMax : arm_cnt_q + 1'b1;
  assign open_inc = (open_cnt_q == CountMax) ? CountMax : open_cnt_q + 1'b1;

  // Phase sequencer: next state and the beat's result.
  always_comb begin
    phase_d    = phase_q;
    arm_cnt_d  = arm_cnt_q;
    open_cnt_d = open_cnt_q;
    kept_d     = kept_q;
    last_x_d   = last_x_q;
    last_y_d   = last_y_q;
    res_o      = '0;

    unique case (phase_q)
      PH_ARM: begin
        if (item_i.hand_closed) begin
          arm_cnt_d = arm_inc;
          if (arm_inc >= cfg_i.arm_frames) begin
            phase_d   = PH_COLLECT;
            arm_cnt_d = '0;
            last_x_d  = item_i.point_x;
            last_y_d  = item_i.point_y;
          end
        end
      end
      PH_COLLECT: begin
        if (item_i.hand_closed) begin
          if (in_bounds) begin
            res_o.append_point = 1'b1;
            res_o.kept_x       = item_i.point_x;
            res_o.kept_y       = item_i.point_y;
            last_x_d           = item_i.point_x;
            last_y_d           = item_i.point_y;
            kept_d = (kept_q == PointsMax) ? PointsMax : kept_q + 1'b1;
          end
          open_cnt_d = '0;
        end else begin
          open_cnt_d = open_inc;
          if (open_inc >= cfg_i.release_frames) begin
            phase_d = PH_IDLE;
            if (kept_q >= cfg_i.min_points) begin
              res_o.gesture_ready = 1'b1;
              res_o.trim_count    = cfg_i.tail_trim;
            end
          end
        end
      end
      default: begin
        // Idle, and the unused code treated as idle.
        if (item_i.hand_closed) begin
          phase_d              = PH_ARM;
          res_o.clear_sequence = 1'b1;
          kept_d               = '0;
          open_cnt_d           = '0;
        end else begin
          phase_d = PH_IDLE;
        end
        arm_cnt_d = '0;
      end
    endcase

    res_o.phase = phase_d;
  end

  // Advance state only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      arm_cnt_q  <= '0;
      open_cnt_q <= '0;
      kept_q     <= '0;
      last_x_q   <= '0;
      last_y_q   <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      arm_cnt_q  <= arm_cnt_d;
      open_cnt_q <= open_cnt_d;
      kept_q     <= kept_d;
      last_x_q   <= last_x_d;
      last_y_q   <= last_y_d;
    end
  end

  `GTS_ASSERT(a_clear_enters_arm, clk_i, rst_ni,
              fire_i && res_o.clear_sequence |=> phase_q == PH_ARM && kept_q == '0)
  `GTS_ASSERT(a_ready_ends_collect, clk_i, rst_ni,
              fire_i && res_o.gesture_ready |-> phase_q == PH_COLLECT && phase_d == PH_IDLE)
  `GTS_ASSERT(a_append_moves_last, clk_i, rst_ni,
              fire_i && res_o.append_point |=> last_x_q == $past(item_i.point_x)
              && last_y_q == $past(item_i.point_y))
  `GTS_ASSERT_NEVER(a_append_outside_collect, clk_i, rst_ni,
                    res_o.append_point && phase_q != PH_COLLECT)

endmodule

// File: rtl/gesture_trajectory_segmenter_top.sv
// Channel | Handshake                   | Beat contents
// --------+-----------------------------+-------------------------------------
// in      | in_valid_i / in_ready_o     | hand_closed, point_x, point_y
// out     | out_valid_o / out_ready_i   | append_point .. phase
// cfg     | psel, penable, pwrite       | paddr, pwdata, prdata (pready high)
//
// One frame per cycle while the output is not stalled; a result is offered once
// its frame has passed the input register, sequencer and output register.
// Reset (rst_ni low, asynchronous) empties both registers, returns the phase
// to idle and loads the register defaults.
// A stalled output holds its result; the input register takes one more frame,
// then in_ready_o drops until the output moves.
module gesture_trajectory_segmenter_top import gts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              hand_closed_i,
  input  logic [CoordW-1:0] point_x_i,
  input  logic [CoordW-1:0] point_y_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              append_point_o,
  output logic [CoordW-1:0] kept_x_o,
  output logic [CoordW-1:0] kept_y_o,
  output logic              clear_sequence_o,
  output logic              gesture_ready_o,
  output logic [CountW-1:0] trim_count_o,
  output logic [1:0]        phase_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  cfg_t  cfg;
  item_t item_q;
  logic  in_vld_q;
  res_t  res_d, res_q;
  logic  out_vld_q;
  logic  advance;

  gts_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move a frame through the sequencer when the output slot is free.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.hand_closed <= hand_closed_i;
      item_q.point_x     <= point_x_i;
      item_q.point_y     <= point_y_i;
    end
  end

  gts_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign append_point_o   = res_q.append_point;
  assign kept_x_o         = res_q.kept_x;
  assign kept_y_o         = res_q.kept_y;
  assign clear_sequence_o = res_q.clear_sequence;
  assign gesture_ready_o  = res_q.gesture_ready;
  assign trim_count_o     = res_q.trim_count;
  assign phase_o          = res_q.phase;

endmodule

// File: verif/gesture_trajectory_segmenter_top_test.sv
`timescale 1ns / 1ps

module gesture_trajectory_segmenter_top_test;
  import gts_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned PrintLimit = 60;
  localparam int unsigned StepAll    = (1 << StepSqW) - 1;
  localparam int unsigned FarStepSq  = 2 * 4095 * 4095;
  localparam logic [CoordW-1:0] CoordTop = '1;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              hand_closed_i;
  logic [CoordW-1:0] point_x_i;
  logic [CoordW-1:0] point_y_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              append_point_o;
  logic [CoordW-1:0] kept_x_o;
  logic [CoordW-1:0] kept_y_o;
  logic              clear_sequence_o;
  logic              gesture_ready_o;
  logic [CountW-1:0] trim_count_o;
  logic [1:0]        phase_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // Predicted segmenter state and register copy
  cfg_t               cfg;
  phase_e             seg_phase;
  logic [CountW-1:0]  arm_seen;
  logic [CountW-1:0]  open_run;
  logic [PointsW-1:0] kept_cnt;
  logic [CoordW-1:0]  last_px;
  logic [CoordW-1:0]  last_py;

  res_t        pending_results[$];
  int unsigned frames_sent = 0;
  int unsigned mismatches  = 0;
  bit          tx_random   = 1'b1;
  bit          rx_random   = 1'b1;
  int unsigned rx_hold_len = 0;

  gesture_trajectory_segmenter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .hand_closed_i    (hand_closed_i),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .append_point_o   (append_point_o),
    .kept_x_o         (kept_x_o),
    .kept_y_o         (kept_y_o),
    .clear_sequence_o (clear_sequence_o),
    .gesture_ready_o  (gesture_ready_o),
    .trim_count_o     (trim_count_o),
    .phase_o          (phase_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= PrintLimit) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Advance the predicted segmenter by one frame
  function automatic res_t step_segmenter(item_t f);
    res_t        r;
    int unsigned dx;
    int unsigned dy;
    int unsigned d2;
    r = '0;
    case (seg_phase)
      PH_ARM: begin
        if (f.hand_closed) begin
          if (arm_seen != CountMax) arm_seen++;
          if (arm_seen >= cfg.arm_frames) begin
            seg_phase = PH_COLLECT;
            arm_seen  = '0;
            last_px   = f.point_x;
            last_py   = f.point_y;
          end
        end
      end
      PH_COLLECT: begin
        if (f.hand_closed) begin
          dx = (f.point_x > last_px) ? f.point_x - last_px : last_px - f.point_x;
          dy = (f.point_y > last_py) ? f.point_y - last_py : last_py - f.point_y;
          d2 = dx * dx + dy * dy;
          if (d2 >= cfg.min_step_sq && d2 <= cfg.max_step_sq) begin
            r.append_point = 1'b1;
            r.kept_x       = f.point_x;
            r.kept_y       = f.point_y;
            last_px        = f.point_x;
            last_py        = f.point_y;
            if (kept_cnt != PointsMax) kept_cnt++;
          end
          open_run = '0;
        end else begin
          if (open_run != CountMax) open_run++;
          if (open_run >= cfg.release_frames) begin
            seg_phase = PH_IDLE;
            if (kept_cnt >= cfg.min_points) begin
              r.gesture_ready = 1'b1;
              r.trim_count    = cfg.tail_trim;
            end
          end
        end
      end
      default: begin
        if (f.hand_closed) begin
          seg_phase        = PH_ARM;
          r.clear_sequence = 1'b1;
          kept_cnt         = '0;
          open_run         = '0;
        end else begin
          seg_phase = PH_IDLE;
        end
        arm_seen = '0;
      end
    endcase
    r.phase = seg_phase;
    return r;
  endfunction

  // Offer one frame, hold it until taken, predict, then maybe idle
  task automatic send_frame(item_t f);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    hand_closed_i <= f.hand_closed;
    point_x_i     <= f.point_x;
    point_y_i     <= f.point_y;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(step_segmenter(f));
    frames_sent++;
    gap = tx_random ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic item_t frame(logic closed, logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    item_t f;
    f.hand_closed = closed;
    f.point_x     = x;
    f.point_y     = y;
    return f;
  endfunction

  function automatic item_t random_frame(logic closed);
    return frame(closed, CoordW'($urandom()), CoordW'($urandom()));
  endfunction

  function automatic logic [CoordW-1:0] nudge(logic [CoordW-1:0] base, int unsigned span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - int'(span);
    if (v < 0) v = 0;
    if (v > int'(CoordTop)) v = int'(CoordTop);
    return CoordW'(v);
  endfunction

  // Closed frame near the last kept point, sometimes a jump to a corner
  function automatic item_t next_closed();
    int unsigned sel;
    int unsigned span;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      return frame(1'b1, $urandom_range(0, 1) ? CoordTop : '0,
                   $urandom_range(0, 1) ? CoordTop : '0);
    end
    span = (sel < 4) ? 3 : (sel < 13) ? 60 : (sel < 17) ? 150 : 2000;
    return frame(1'b1, nudge(last_px, span), nudge(last_py, span));
  endfunction

  // Arm, collect n_steps frames with short open runs, then release
  task automatic run_gesture(int unsigned n_steps);
    int unsigned k;
    if (seg_phase == PH_IDLE) begin
      repeat ($urandom_range(0, 2)) send_frame(random_frame(1'b0));
      send_frame(random_frame(1'b1));
    end
    while (seg_phase == PH_ARM) begin
      send_frame(random_frame($urandom_range(0, 4) != 0));
    end
    k = 0;
    while (seg_phase == PH_COLLECT && k < n_steps) begin
      if (cfg.release_frames > 1 && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, cfg.release_frames - 1)) send_frame(random_frame(1'b0));
      end else begin
        send_frame(next_closed());
      end
      k++;
    end
    while (seg_phase == PH_COLLECT) send_frame(random_frame(1'b0));
  endtask

  // Stop offering and wait out every pending result plus the pipeline
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] value);
    case (idx)
      REG_ARM_FRAMES:     cfg.arm_frames     = value[CountW-1:0];
      REG_RELEASE_FRAMES: cfg.release_frames = value[CountW-1:0];
      REG_MIN_STEP_SQ:    cfg.min_step_sq    = value[StepSqW-1:0];
      REG_MAX_STEP_SQ:    cfg.max_step_sq    = value[StepSqW-1:0];
      REG_MIN_POINTS:     cfg.min_points     = value[PointsW-1:0];
      REG_TAIL_TRIM:      cfg.tail_trim      = value[CountW-1:0];
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_reg_check(reg_idx_e idx);
    logic [DataW-1:0] want;
    case (idx)
      REG_ARM_FRAMES:     want = cfg.arm_frames;
      REG_RELEASE_FRAMES: want = cfg.release_frames;
      REG_MIN_STEP_SQ:    want = cfg.min_step_sq;
      REG_MAX_STEP_SQ:    want = cfg.max_step_sq;
      REG_MIN_POINTS:     want = cfg.min_points;
      REG_TAIL_TRIM:      want = cfg.tail_trim;
      default:            want = '0;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      flag_mismatch($sformatf("register %s reads %0d, want %0d", idx.name(), prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_registers();
    for (int i = 0; i <= REG_TAIL_TRIM; i++) read_reg_check(reg_idx_e'(i));
  endtask

  task automatic apply_config(int unsigned arm, int unsigned rel, int unsigned lo,
                              int unsigned hi, int unsigned pts, int unsigned trim);
    drain_results();
    write_reg(REG_ARM_FRAMES, arm);
    write_reg(REG_RELEASE_FRAMES, rel);
    write_reg(REG_MIN_STEP_SQ, lo);
    write_reg(REG_MAX_STEP_SQ, hi);
    write_reg(REG_MIN_POINTS, pts);
    write_reg(REG_TAIL_TRIM, trim);
    check_registers();
  endtask

  task automatic test_register_defaults();
    check_registers();
  endtask

  // Step through one short gesture by hand with the reset settings
  task automatic test_basic_gesture();
    send_frame(frame(1'b0, '0, '0));
    send_frame(frame(1'b1, CoordTop, CoordTop));
    send_frame(frame(1'b0, '0, CoordTop));
    send_frame(frame(1'b1, CoordTop, '0));
    send_frame(frame(1'b0, 12'd123, 12'd456));
    send_frame(frame(1'b1, 12'd7, 12'd9));
    send_frame(frame(1'b1, 12'd1000, 12'd1000));
    // below, at the low bound, at the high bound, above
    send_frame(frame(1'b1, 12'd1002, 12'd1000));
    send_frame(frame(1'b1, 12'd1004, 12'd1000));
    send_frame(frame(1'b1, 12'd1104, 12'd1000));
    send_frame(frame(1'b1, 12'd1205, 12'd1000));
    send_frame(frame(1'b1, 12'd1150, 12'd1050));
    // open run cut short by a closed frame
    send_frame(frame(1'b0, 12'd1, 12'd2));
    send_frame(frame(1'b0, 12'd3, 12'd4));
    send_frame(frame(1'b1, 12'd1160, 12'd1050));
    // release with too few points
    repeat (3) send_frame(frame(1'b0, 12'd2048, 12'd2048));
    send_frame(frame(1'b0, CoordTop, '0));
  endtask

  task automatic test_register_extremes();
    // zero arm and release, no minimum, every gesture ready
    apply_config(0, 0, 0, StepAll, 0, 15);
    repeat (4) run_gesture($urandom_range(1, 6));

    // slowest arming and release, only diagonal jumps are accepted
    apply_config(15, 15, FarStepSq, FarStepSq, 1023, 0);
    repeat (16) send_frame(frame(1'b1, '0, '0));
    send_frame(frame(1'b1, CoordTop, CoordTop));
    send_frame(frame(1'b1, CoordTop, '0));
    send_frame(frame(1'b1, '0, '0));
    repeat (15) send_frame(frame(1'b0, CoordTop, CoordTop));
    repeat (2) run_gesture($urandom_range(5, 12));

    // crossed bounds accept nothing
    apply_config(2, 3, 5000, 4000, 0, 9);
    repeat (3) run_gesture(8);

    apply_config(1, 1, 16, 400, 1, 4);
    repeat (4) run_gesture($urandom_range(2, 10));
  endtask

  // Keep more points than the counter holds; it must stick at its top
  task automatic test_count_saturation();
    apply_config(1, 1, 0, StepAll, 1023, 7);
    run_gesture(1030);
  endtask

  // Stall the result side long enough to fill the block, then pause
  task automatic test_backpressure();
    apply_config(RstArmFrames, RstReleaseFrames, RstMinStepSq, RstMaxStepSq,
                 RstMinPoints, RstTailTrim);
    tx_random   = 1'b0;
    rx_hold_len = 150;
    run_gesture(40);
    tx_random = 1'b1;
    drain_results();
  endtask

  task automatic test_random_gestures();
    int unsigned stop_at;
    int unsigned hi_pick;
    int unsigned hi;
    for (int pass_no = 0; pass_no < 8; pass_no++) begin
      hi_pick = $urandom_range(0, 4);
      hi = (hi_pick < 3) ? $urandom_range(1000, 40000) :
           (hi_pick == 3) ? ($urandom() & StepAll) : StepAll;
      apply_config($urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(0, 15),
                   $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(0, 15),
                   $urandom_range(0, 1) ? $urandom_range(0, 64) :
                     ($urandom_range(0, 1) ? $urandom_range(0, 2000) : ($urandom() & StepAll)),
                   hi,
                   $urandom_range(0, 9) < 7 ? $urandom_range(0, 12) : $urandom_range(0, 1023),
                   $urandom_range(0, 15));
      tx_random = (pass_no % 3 != 1);
      rx_random = tx_random;
      stop_at   = frames_sent + 50;
      while (frames_sent < stop_at) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 6)) send_frame(random_frame(1'($urandom_range(0, 1))));
        end else begin
          run_gesture($urandom_range(1, 16));
        end
      end
    end
    tx_random = 1'b1;
    rx_random = 1'b1;
  endtask

  // Result side: random stalls, or a long hold when asked
  initial begin : rx_drive
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len != 0) begin
        stall_left  = rx_hold_len;
        rx_hold_len = 0;
      end else if (stall_left == 0 && rx_random && $urandom_range(0, 2) == 0) begin
        stall_left = idle_len();
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result beat with no frame pending");
      end else begin
        want = pending_results.pop_front();
        if (append_point_o !== want.append_point)
          flag_mismatch($sformatf("append_point %0d, want %0d", append_point_o, want.append_point));
        if (kept_x_o !== want.kept_x)
          flag_mismatch($sformatf("kept_x %0d, want %0d", kept_x_o, want.kept_x));
        if (kept_y_o !== want.kept_y)
          flag_mismatch($sformatf("kept_y %0d, want %0d", kept_y_o, want.kept_y));
        if (clear_sequence_o !== want.clear_sequence)
          flag_mismatch($sformatf("clear_sequence %0d, want %0d", clear_sequence_o,
                                  want.clear_sequence));
        if (gesture_ready_o !== want.gesture_ready)
          flag_mismatch($sformatf("gesture_ready %0d, want %0d", gesture_ready_o,
                                  want.gesture_ready));
        if (trim_count_o !== want.trim_count)
          flag_mismatch($sformatf("trim_count %0d, want %0d", trim_count_o, want.trim_count));
        if (phase_o !== want.phase)
          flag_mismatch($sformatf("phase %0d, want %0d", phase_o, want.phase));
      end
    end
  end

  // End the run when no beat moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : run
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    hand_closed_i = 1'b0;
    point_x_i     = '0;
    point_y_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cfg.arm_frames     = RstArmFrames;
    cfg.release_frames = RstReleaseFrames;
    cfg.min_step_sq    = RstMinStepSq;
    cfg.max_step_sq    = RstMaxStepSq;
    cfg.min_points     = RstMinPoints;
    cfg.tail_trim      = RstTailTrim;
    seg_phase = PH_IDLE;
    arm_seen  = '0;
    open_run  = '0;
    kept_cnt  = '0;
    last_px   = '0;
    last_py   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_defaults();
    test_basic_gesture();
    test_register_extremes();
    test_count_saturation();
    test_backpressure();
    test_random_gestures();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: gesture_trajectory_segmenter_top.f
+incdir+rtl
rtl/gts_pkg.sv
rtl/gts_cfg_regs.sv
rtl/gts_core.sv
rtl/gesture_trajectory_segmenter_top.sv
verif/gesture_trajectory_segmenter_top_test.sv
